>>> rtl/evr_pkg.sv
// Shared constants and helper functions for the XYZ Euler vector rotator.
package evr_pkg;

  // Coordinate and trig word widths.
  localparam int COORD_W = 32;
  localparam int TRIG_W  = 32;
  localparam int ANGLE_W = 17;
  localparam int CORD_W  = 34;
  localparam int MAX_STEPS = 32;

  // Angle reduction: one full turn in 1/128 degree units.
  localparam logic signed [17:0] TURN_UNITS = 18'sd46080;
  localparam logic signed [17:0] TWO_TURNS  = 18'sd92160;

  // floor(2^46 / 45): turns r * 2^22 / 45 into a multiply and a shift.
  localparam logic [40:0] RECIP_K = 41'((64'd1 << 46) / 64'd45);
  localparam logic [37:0] DIV_45  = 38'd45;

  // Trig scale is Q2.30.
  localparam logic signed [CORD_W-1:0] TRIG_ONE    = 34'sd1073741824;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [32:0] QUARTER  = 33'sd1073741824;
  localparam logic signed [32:0] HALF_BAM = 33'sd2147483648;

  // Arctangent of 2^-i as a binary angle where a full turn is 2^32.
  function automatic logic signed [CORD_W-1:0] atan_bam(input int unsigned i);
    logic signed [CORD_W-1:0] v;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      28: v = 34'sd3;
      29: v = 34'sd1;
      30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Saturate a 36-bit coordinate to 32 bits; the top bit flags a clamp.
  function automatic logic [COORD_W:0] clamp32(input logic signed [35:0] v);
    logic [COORD_W:0] r;
    if (v > 36'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -36'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[COORD_W-1:0]};
    end
    return r;
  endfunction

endpackage

>>> rtl/euler_xyz_vector_rotate.sv
// Top level of the XYZ Euler vector rotator.
// Usage: drive start with one point and three angles; a new item may enter on
// every clock, so busy stays low. The rotated point appears on out_x, out_y,
// out_z with out_saturated and a one-cycle out_valid strobe after acceptance;
// CORDIC iterations are capped at 32. The path runs through the three
// parallel CORDIC pipelines (one stage per iteration plus five for angle
// reduction and finishing), then three two-stage rotation multipliers and
// one saturation register. The receiver cannot stall the output, so
// results must be taken when strobed.
module euler_xyz_vector_rotate #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic signed [16:0]  in_angle_about_x,
  input  logic signed [16:0]  in_angle_about_y,
  input  logic signed [16:0]  in_angle_about_z,
  output logic                out_valid,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                out_saturated
);
  import evr_pkg::*;

  localparam int Steps   = (CORDIC_ITERATIONS > MAX_STEPS) ? MAX_STEPS : CORDIC_ITERATIONS;
  localparam int TrigLat = Steps + 5;
  localparam int Latency = TrigLat + 7;

  logic accept;
  logic tvx, tvy, tvz;
  logic signed [31:0] cx, sx, cy, sy, cz, sz;

  logic signed [31:0] xd_r [TrigLat+2];
  logic signed [31:0] yd_r [TrigLat];
  logic signed [31:0] zd_r [TrigLat];
  logic signed [31:0] cyd_r [2];
  logic signed [31:0] syd_r [2];
  logic signed [31:0] czd_r [4];
  logic signed [31:0] szd_r [4];
  logic signed [33:0] y1d_r [2];
  logic signed [34:0] z2d_r [2];

  logic               v1, v2, v3;
  logic signed [33:0] y1, z1;
  logic signed [34:0] x2, z2;
  logic signed [35:0] x3, y3;

  logic [32:0] cl_x, cl_y, cl_z;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic               osat_r, ovld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Sine and cosine for each axis, in parallel.
  evr_trig #(.ITERS(Steps)) u_trig_x (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .in_angle(in_angle_about_x),
    .out_vld(tvx), .out_cos(cx), .out_sin(sx)
  );
  evr_trig #(.ITERS(Steps)) u_trig_y (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .in_angle(in_angle_about_y),
    .out_vld(tvy), .out_cos(cy), .out_sin(sy)
  );
  evr_trig #(.ITERS(Steps)) u_trig_z (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .in_angle(in_angle_about_z),
    .out_vld(tvz), .out_cos(cz), .out_sin(sz)
  );

  // Delay lines that line operands up with the rotation stages.
  always_ff @(posedge clk) begin
    xd_r[0] <= in_x;
    yd_r[0] <= in_y;
    zd_r[0] <= in_z;
    for (int k = 1; k < TrigLat + 2; k++) begin
      xd_r[k] <= xd_r[k-1];
    end
    for (int k = 1; k < TrigLat; k++) begin
      yd_r[k] <= yd_r[k-1];
      zd_r[k] <= zd_r[k-1];
    end
    cyd_r[0] <= cy;
    syd_r[0] <= sy;
    cyd_r[1] <= cyd_r[0];
    syd_r[1] <= syd_r[0];
    czd_r[0] <= cz;
    szd_r[0] <= sz;
    for (int k = 1; k < 4; k++) begin
      czd_r[k] <= czd_r[k-1];
      szd_r[k] <= szd_r[k-1];
    end
    y1d_r[0] <= y1;
    y1d_r[1] <= y1d_r[0];
    z2d_r[0] <= z2;
    z2d_r[1] <= z2d_r[0];
  end

  // Rotation about X: y' = y c - z s, z' = y s + z c.
  evr_rot #(.AW(32), .BW(32), .OW(34), .SUB1(1'b1), .SUB2(1'b0)) u_rot_x (
    .clk(clk), .rst_n(rst_n), .in_vld(tvx),
    .in_a(yd_r[TrigLat-1]), .in_b(zd_r[TrigLat-1]), .in_cos(cx), .in_sin(sx),
    .out_vld(v1), .out_p(y1), .out_q(z1)
  );

  // Rotation about Y: x' = x c + z s, z' = z c - x s.
  evr_rot #(.AW(32), .BW(34), .OW(35), .SUB1(1'b0), .SUB2(1'b1)) u_rot_y (
    .clk(clk), .rst_n(rst_n), .in_vld(v1),
    .in_a(xd_r[TrigLat+1]), .in_b(z1), .in_cos(cyd_r[1]), .in_sin(syd_r[1]),
    .out_vld(v2), .out_p(x2), .out_q(z2)
  );

  // Rotation about Z: x' = x c - y s, y' = x s + y c.
  evr_rot #(.AW(35), .BW(34), .OW(36), .SUB1(1'b1), .SUB2(1'b0)) u_rot_z (
    .clk(clk), .rst_n(rst_n), .in_vld(v2),
    .in_a(x2), .in_b(y1d_r[1]), .in_cos(czd_r[3]), .in_sin(szd_r[3]),
    .out_vld(v3), .out_p(x3), .out_q(y3)
  );

  // Saturate each component to 32 bits.
  always_comb begin
    cl_x = clamp32(x3);
    cl_y = clamp32(y3);
    cl_z = clamp32(36'(z2d_r[1]));
  end

  always_ff @(posedge clk) begin
    ox_r   <= cl_x[31:0];
    oy_r   <= cl_y[31:0];
    oz_r   <= cl_z[31:0];
    osat_r <= cl_x[32] | cl_y[32] | cl_z[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= v3;
    end
  end

  assign out_valid     = ovld_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_saturated = osat_r;

  // The three trig pipelines run in lockstep.
  a_trig_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (tvx == tvy) && (tvx == tvz))
    else $error("trig pipelines out of step");

  // Every result traces back to an accepted item.
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, Latency))
    else $error("result without an accepted item");

  // Every accepted item produces a result.
  a_item_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##Latency out_valid)
    else $error("accepted item lost");

  // A saturation flag implies some component sits at a 32-bit limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_x == 32'sh7FFF_FFFF) || (out_x == 32'sh8000_0000) ||
      (out_y == 32'sh7FFF_FFFF) || (out_y == 32'sh8000_0000) ||
      (out_z == 32'sh7FFF_FFFF) || (out_z == 32'sh8000_0000))
    else $error("saturation flag without a clamped component");

endmodule

>>> rtl/evr_trig.sv
// Pipelined angle reduction and CORDIC sine/cosine generator.
module evr_trig #(
  parameter int ITERS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic signed [16:0]         in_angle,
  output logic                       out_vld,
  output logic signed [31:0]         out_cos,
  output logic signed [31:0]         out_sin
);
  import evr_pkg::*;

  logic [15:0]               r_r, r2_r;
  logic [56:0]               prod_r;
  logic [31:0]               q_r;
  logic signed [CORD_W-1:0]  z0_r;
  logic                      neg0_r;
  logic                      va_r, vb_r, vc_r, vd_r;
  logic signed [CORD_W-1:0]  cx_r [ITERS];
  logic signed [CORD_W-1:0]  cy_r [ITERS];
  logic signed [CORD_W-1:0]  cz_r [ITERS];
  logic                      cn_r [ITERS];
  logic                      cv_r [ITERS];
  logic signed [31:0]        cos_r, sin_r;
  logic                      out_vld_r;

  logic signed [17:0]        a_ext, a_p1, a_p2, a_m1, r_sel;
  logic [56:0]               prod_nxt;
  logic [32:0]               q_est;
  logic [37:0]               num, qm, rem;
  logic [31:0]               q_nxt;
  logic signed [32:0]        ts, tf;
  logic                      neg_nxt;
  logic signed [CORD_W-1:0]  fx, fy, cx_lim, cy_lim;

  // Reduce the angle into one turn.
  always_comb begin
    a_ext = {in_angle[16], in_angle};
    a_p1  = a_ext + TURN_UNITS;
    a_p2  = a_ext + TWO_TURNS;
    a_m1  = a_ext - TURN_UNITS;
    if (a_ext < 18'sd0) begin
      r_sel = (a_p1 < 18'sd0) ? a_p2 : a_p1;
    end else begin
      r_sel = (a_ext >= TURN_UNITS) ? a_m1 : a_ext;
    end
  end

  // Reciprocal multiply for the division by 45, then its correction.
  assign prod_nxt = 57'(r_r) * 57'(RECIP_K);
  always_comb begin
    q_est = prod_r[56:24];
    num   = {r2_r, 22'b0};
    qm    = 38'(q_est) * DIV_45;
    rem   = num - qm;
    q_nxt = (rem >= DIV_45) ? (q_est[31:0] + 32'd1) : q_est[31:0];
  end

  // Fold angles beyond a quarter turn back into CORDIC range.
  always_comb begin
    ts      = {q_r[31], q_r};
    tf      = ts;
    neg_nxt = 1'b0;
    if (ts > QUARTER) begin
      tf      = ts - HALF_BAM;
      neg_nxt = 1'b1;
    end else if (ts < -QUARTER) begin
      tf      = ts + HALF_BAM;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    r_r    <= r_sel[15:0];
    prod_r <= prod_nxt;
    r2_r   <= r_r;
    q_r    <= q_nxt;
    z0_r   <= CORD_W'(tf);
    neg0_r <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // One CORDIC micro-rotation per stage.
  for (genvar k = 0; k < ITERS; k++) begin : g_step
    logic signed [CORD_W-1:0] xi, yi, zi;
    logic                     ni, vi;
    if (k == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z0_r;
      assign ni = neg0_r;
      assign vi = vd_r;
    end else begin : g_rest
      assign xi = cx_r[k-1];
      assign yi = cy_r[k-1];
      assign zi = cz_r[k-1];
      assign ni = cn_r[k-1];
      assign vi = cv_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!zi[CORD_W-1]) begin
        cx_r[k] <= xi - (yi >>> k);
        cy_r[k] <= yi + (xi >>> k);
        cz_r[k] <= zi - atan_bam(k);
      end else begin
        cx_r[k] <= xi + (yi >>> k);
        cy_r[k] <= yi - (xi >>> k);
        cz_r[k] <= zi + atan_bam(k);
      end
      cn_r[k] <= ni;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k] <= 1'b0;
      end else begin
        cv_r[k] <= vi;
      end
    end
  end

  // Undo the fold and clamp to plus or minus one.
  always_comb begin
    fx = cn_r[ITERS-1] ? -cx_r[ITERS-1] : cx_r[ITERS-1];
    fy = cn_r[ITERS-1] ? -cy_r[ITERS-1] : cy_r[ITERS-1];
    cx_lim = (fx > TRIG_ONE) ? TRIG_ONE : ((fx < -TRIG_ONE) ? -TRIG_ONE : fx);
    cy_lim = (fy > TRIG_ONE) ? TRIG_ONE : ((fy < -TRIG_ONE) ? -TRIG_ONE : fy);
  end

  always_ff @(posedge clk) begin
    cos_r <= cx_lim[31:0];
    sin_r <= cy_lim[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cv_r[ITERS-1];
    end
  end

  assign out_vld = out_vld_r;
  assign out_cos = cos_r;
  assign out_sin = sin_r;

endmodule

>>> rtl/evr_rot.sv
// Two-stage planar rotation of a coordinate pair by a given cosine and sine.
module evr_rot #(
  parameter int AW   = 32,
  parameter int BW   = 32,
  parameter int OW   = 34,
  parameter bit SUB1 = 1'b0,
  parameter bit SUB2 = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [AW-1:0] in_a,
  input  logic signed [BW-1:0] in_b,
  input  logic signed [31:0]   in_cos,
  input  logic signed [31:0]   in_sin,
  output logic                 out_vld,
  output logic signed [OW-1:0] out_p,
  output logic signed [OW-1:0] out_q
);
  import evr_pkg::*;

  localparam int PW = ((AW > BW) ? AW : BW) + TRIG_W + 1;
  localparam logic signed [PW-1:0] ROUND = PW'(64'd1 << 29);

  logic signed [PW-1:0] pac_r, pbs_r, pas_r, pbc_r;
  logic signed [PW-1:0] sum_p, sum_q;
  logic signed [OW-1:0] p_r, q_r;
  logic                 v1_r, v2_r;

  // Stage one: the four products.
  always_ff @(posedge clk) begin
    pac_r <= PW'(in_a) * PW'(in_cos);
    pbs_r <= PW'(in_b) * PW'(in_sin);
    pas_r <= PW'(in_a) * PW'(in_sin);
    pbc_r <= PW'(in_b) * PW'(in_cos);
  end

  // Stage two: combine, round half up and drop the Q2.30 scale.
  always_comb begin
    sum_p = (SUB1 ? (pac_r - pbs_r) : (pac_r + pbs_r)) + ROUND;
    sum_q = (SUB2 ? (pbc_r - pas_r) : (pbc_r + pas_r)) + ROUND;
  end

  always_ff @(posedge clk) begin
    p_r <= sum_p[OW+29:30];
    q_r <= sum_q[OW+29:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  assign out_vld = v2_r;
  assign out_p   = p_r;
  assign out_q   = q_r;

endmodule

>>> tb/evr_rotation_checker.sv
// Checker that predicts and compares every rotated point of the Euler rotator.
`timescale 1ns / 1ps

module evr_rotation_checker #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [16:0] in_angle_about_x,
  input  logic signed [16:0] in_angle_about_y,
  input  logic signed [16:0] in_angle_about_z,
  input  logic               out_valid,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 points_pending
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } rotated_point_t;

  localparam longint TURN     = 46080;
  localparam longint UNIT_Q30 = 64'sd1073741824;
  localparam longint GAIN_Q30 = 64'sd652032874;

  rotated_point_t expected_points[$];

  // Arctangent of 2^-i as a binary angle, a full turn being 2^32.
  function automatic longint arctan_step(input int i);
    longint steps[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
    return steps[i];
  endfunction

  // Cosine and sine of an angle in 1/128 degree, both in Q2.30.
  task automatic angle_trig(input logic signed [16:0] ang, output longint cs,
                            output longint sn);
    longint r, t, cx, cy, cz, nx;
    bit     flip;
    r = longint'(ang) % TURN;
    if (r < 0) r += TURN;
    t = (r << 25) / 360;
    if (t >= 64'sd2147483648) t -= 64'sd4294967296;
    flip = 1'b0;
    // Fold angles beyond a quarter turn and negate the result afterwards.
    if (t > UNIT_Q30) begin
      t -= 64'sd2147483648;
      flip = 1'b1;
    end else if (t < -UNIT_Q30) begin
      t += 64'sd2147483648;
      flip = 1'b1;
    end
    cx = GAIN_Q30;
    cy = 0;
    cz = t;
    for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz -= arctan_step(i);
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz += arctan_step(i);
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    if (cx > UNIT_Q30) cx = UNIT_Q30;
    if (cx < -UNIT_Q30) cx = -UNIT_Q30;
    if (cy > UNIT_Q30) cy = UNIT_Q30;
    if (cy < -UNIT_Q30) cy = -UNIT_Q30;
    cs = cx;
    sn = cy;
  endtask

  // One mixed coordinate, rounding halves upward.
  function automatic longint mix_q30(input longint a, input longint c,
                                     input longint b, input longint s);
    return (a * c + b * s + (UNIT_Q30 >>> 1)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v,
                                                     inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Rotate about X, then Y, then Z, each applied to the result of the one before.
  task automatic rotate_point(output rotated_point_t p);
    longint x, y, z, c, s, t;
    logic   sat;
    x = longint'(in_x);
    y = longint'(in_y);
    z = longint'(in_z);
    sat = 1'b0;
    angle_trig(in_angle_about_x, c, s);
    t = mix_q30(y, c, z, -s);
    z = mix_q30(y, s, z, c);
    y = t;
    angle_trig(in_angle_about_y, c, s);
    t = mix_q30(x, c, z, s);
    z = mix_q30(x, -s, z, c);
    x = t;
    angle_trig(in_angle_about_z, c, s);
    t = mix_q30(x, c, y, -s);
    y = mix_q30(x, s, y, c);
    x = t;
    p.x = clamp_coord(x, sat);
    p.y = clamp_coord(y, sat);
    p.z = clamp_coord(z, sat);
    p.sat = sat;
  endtask

  // Predict on each accepted item; compare each strobed result with the oldest one.
  always @(posedge clk) begin
    rotated_point_t p;
    rotated_point_t e;
    if (!rst_n) begin
      fail_count = 0;
      expected_points.delete();
      points_pending = 0;
    end else begin
      if (start && !busy) begin
        rotate_point(p);
        expected_points.push_back(p);
      end
      if (out_valid) begin
        if (expected_points.size() == 0) begin
          $error("result with no item outstanding: x=%0d y=%0d z=%0d", out_x, out_y,
                 out_z);
          fail_count++;
        end else begin
          e = expected_points.pop_front();
          if (out_x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, out_x);
            fail_count++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, out_y);
            fail_count++;
          end
          if (out_z !== e.z) begin
            $error("out_z expected %0d actual %0d", e.z, out_z);
            fail_count++;
          end
          if (out_saturated !== e.sat) begin
            $error("out_saturated expected %0b actual %0b", e.sat, out_saturated);
            fail_count++;
          end
        end
      end
      points_pending = expected_points.size();
    end
  end

endmodule

>>> tb/euler_xyz_vector_rotate_test.sv
// Testbench top for the Euler rotator: stimulus, checker hookup and verdict.
`timescale 1ns / 1ps

module euler_xyz_vector_rotate_test;

  localparam int STEPS        = 24;
  localparam int ANGLE_MAX    = 46080;
  localparam int RANDOM_ITEMS = 1530;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_x, in_y, in_z;
  logic signed [16:0] in_angle_about_x, in_angle_about_y, in_angle_about_z;
  logic               out_valid;
  logic signed [31:0] out_x, out_y, out_z;
  logic               out_saturated;
  int                 fail_count;
  int                 points_pending;

  euler_xyz_vector_rotate #(.CORDIC_ITERATIONS(STEPS)) u_top (.*);

  evr_rotation_checker #(.CORDIC_ITERATIONS(STEPS)) u_checker (.*);

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input int ax, input int ay,
                            input int az);
    start <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    in_angle_about_x <= 17'(ax);
    in_angle_about_y <= 17'(ay);
    in_angle_about_z <= 17'(az);
    forever begin
      @(negedge clk);
      if (!busy) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic int random_angle();
    int pick;
    pick = $urandom_range(0, 9);
    // Now and then a multiple of 90 degrees, where the quarter-turn folds sit.
    if (pick == 0) return 11520 * ($urandom_range(0, 8) - 4);
    if (pick == 1) return 11520 * ($urandom_range(0, 8) - 4) + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX;
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1: return 32'($urandom_range(0, 1 << 20)) - 32'sd524288;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    in_angle_about_x = '0;
    in_angle_about_y = '0;
    in_angle_about_z = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points: extremes, quarter and half turns, full-turn limits, clamping.
    send_point(0, 0, 0, 0, 0, 0);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, -1, 23040, 23040, 23040);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 11520, 0, 0);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -11520, 11520, -11520);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, ANGLE_MAX, -ANGLE_MAX, 0);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 11521, 11519, -11521);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 34560, -34560, 34561);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 65535, -65536, 50000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5760, 5760, 5760);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 5760, 0, -5760);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 5760, 0);
    send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1, -1, 46079);
    send_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0, -46079, 43690, -21845);
    send_point(-1, 1, -1, 128, -128, 1);
    send_point(32'sh7FFF_FFFF, 0, 0, 0, 0, 11520);
    send_point(0, 32'sh7FFF_FFFF, 0, 11520, 0, 0);
    send_point(0, 0, 32'sh8000_0000, 0, 11520, 0);

    // Random points with random gaps; a stretch in the middle runs back to back.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 800) begin
        start <= 1'b0;
        while (points_pending != 0) @(posedge clk);
      end
      if ((n < 500 || n > 800) && $urandom_range(0, 99) < 39)
        idle_cycles(1);
      send_point(random_coord(), random_coord(), random_coord(), random_angle(),
                 random_angle(), random_angle());
    end
    start <= 1'b0;

    while (points_pending != 0) @(posedge clk);
    repeat (STEPS + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
